[sv/inversion_pair_counter_macros.svh]
// Assertion macros for the inversion pair counter.
// Depends on nothing; included by the RTL files that carry assertions.
`ifndef INVERSION_PAIR_COUNTER_MACROS_SVH
`define INVERSION_PAIR_COUNTER_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define IPC_ASSERT_NOW(lbl, ant, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define IPC_ASSERT_NEXT(lbl, ant, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |=> (cons)) \
        else $error(msg);

`else

`define IPC_ASSERT_NOW(lbl, ant, cons, msg)
`define IPC_ASSERT_NEXT(lbl, ant, cons, msg)

`endif

`endif

[sv/ipc_pkg.sv]
// Shared types and constants for the inversion pair counter.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package ipc_pkg;

    localparam int IN_DATA_W  = 32;
    localparam int TOTAL_W    = 19;
    localparam int OUT_DATA_W = 24;

    localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};

    // Control part of a token that travels down the cell chain.
    typedef struct packed {
        logic valid;   // slot holds an accepted transaction
        logic active;  // item found room: compare and store
        logic ovf;     // item arrived while the store was full
        logic last;    // final item of the sequence
    } tok_ctrl_t;

endpackage

[sv/ipc_cell.sv]
// One cell of the comparison chain: holds one stored value and forwards a token.
// Depends on ipc_pkg.
`timescale 1ns / 1ps

module ipc_cell
    import ipc_pkg::*;
#(
    parameter int INDEX      = 0,
    parameter int VALUE_BITS = 32,
    parameter int IDX_W      = 10
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         adv,
    input  tok_ctrl_t                    in_ctrl,
    input  logic signed [VALUE_BITS-1:0] in_key,
    input  logic        [IDX_W-1:0]      in_target,
    input  logic        [IDX_W-1:0]      in_count,
    output tok_ctrl_t                    out_ctrl,
    output logic signed [VALUE_BITS-1:0] out_key,
    output logic        [IDX_W-1:0]      out_target,
    output logic        [IDX_W-1:0]      out_count
);

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

    logic signed [VALUE_BITS-1:0] stored_reg;
    tok_ctrl_t                    ctrl_reg;
    logic signed [VALUE_BITS-1:0] key_reg;
    logic        [IDX_W-1:0]      target_reg;
    logic        [IDX_W-1:0]      count_reg;

    logic            live;
    logic            hit;
    logic            store_en;
    logic [IDX_W-1:0] count_next;

    // Cells below the target hold earlier items of the same sequence.
    assign live       = in_ctrl.valid && in_ctrl.active;
    assign hit        = live && (MY_IDX < in_target) && (stored_reg > in_key);
    assign store_en   = adv && live && (in_target == MY_IDX);
    assign count_next = in_count + IDX_W'(hit);

    always_ff @(posedge clk)
    begin
        if (store_en)
        begin
            stored_reg <= in_key;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl_reg <= '0;
        end
        else if (adv)
        begin
            ctrl_reg <= in_ctrl;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            key_reg    <= in_key;
            target_reg <= in_target;
            count_reg  <= count_next;
        end
    end

    assign out_ctrl   = ctrl_reg;
    assign out_key    = key_reg;
    assign out_target = target_reg;
    assign out_count  = count_reg;

endmodule

[sv/ipc_tail.sv]
// End of the chain: accumulates per-item counts into the saturating total and
// holds the result register. Depends on ipc_pkg.
`timescale 1ns / 1ps

module ipc_tail
    import ipc_pkg::*;
#(
    parameter int IDX_W = 10
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  adv,
    input  tok_ctrl_t             in_ctrl,
    input  logic [IDX_W-1:0]      in_count,
    input  logic                  m_tready,
    output logic                  m_tvalid,
    output logic [OUT_DATA_W-1:0] m_tdata
);

    localparam int SUM_W = TOTAL_W + 1;

    logic [TOTAL_W-1:0]    total_reg;
    logic                  ovf_reg;
    logic                  out_valid_reg;
    logic [OUT_DATA_W-1:0] out_data_reg;

    logic [SUM_W-1:0]   sum;
    logic [TOTAL_W-1:0] total_sat;
    logic               ovf_next;
    logic               take;

    assign sum       = {1'b0, total_reg} + SUM_W'(in_count);
    assign total_sat = (sum > SUM_W'(TOTAL_MAX)) ? TOTAL_MAX : sum[TOTAL_W-1:0];
    assign ovf_next  = ovf_reg | in_ctrl.ovf;
    assign take      = adv && in_ctrl.valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_reg     <= '0;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (take && in_ctrl.last)
            begin
                total_reg     <= '0;
                ovf_reg       <= 1'b0;
                out_valid_reg <= 1'b1;
            end
            else
            begin
                if (take)
                begin
                    total_reg <= total_sat;
                    ovf_reg   <= ovf_next;
                end
                if (m_tready)
                begin
                    out_valid_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && in_ctrl.last)
        begin
            out_data_reg <= OUT_DATA_W'({ovf_next, total_sat});
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

[sv/inversion_pair_counter.sv]
// Top level of the inversion pair counter: input admission, cell chain, tail.
// Depends on ipc_pkg, ipc_cell, ipc_tail and inversion_pair_counter_macros.svh.
//
//   channel | direction | handshake                    | payload
//   --------+-----------+------------------------------+--------------------------------
//   s_*     | in        | s_tvalid / s_tready          | s_tdata sample_value, s_tlast
//   m_*     | out       | m_tvalid / m_tready          | m_tdata total, capacity flag
//
// One transaction is taken per cycle while the chain advances. Its token walks
// one cell per cycle, under the same condition, down a row of MAX_ITEMS cells, then
// the tail folds its count in and its result register holds the final total.
// Reset clears the tokens, the item count and the totals; stored values need no
// clearing since a cell is only compared once an earlier item has filled it.
// While the result register holds an untaken result the whole chain freezes and
// s_tready drops.
`timescale 1ns / 1ps
`include "inversion_pair_counter_macros.svh"

module inversion_pair_counter
    import ipc_pkg::*;
#(
    parameter int MAX_ITEMS  = 1024,
    parameter int VALUE_BITS = 32
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    // sample_value [31:0]
    input  logic [IN_DATA_W-1:0]  s_tdata,
    input  logic                  s_tlast,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // inversion_total [18:0], capacity_exceeded [19], zero [23:20]
    output logic [OUT_DATA_W-1:0] m_tdata,
    output logic                  m_tvalid,
    input  logic                  m_tready
);

    localparam int IDX_W = $clog2(MAX_ITEMS);
    localparam int SEEN_W = $clog2(MAX_ITEMS + 1);
    localparam logic [SEEN_W-1:0] SEEN_MAX = SEEN_W'(MAX_ITEMS);

    logic [SEEN_W-1:0] seen_count_reg;
    logic [SEEN_W-1:0] seen_count_next;

    logic adv;
    logic accept;
    logic full;

    logic signed [VALUE_BITS-1:0] head_key;

    // Chain taps; tap 0 is the token being admitted this cycle.
    tok_ctrl_t                    tap_ctrl   [MAX_ITEMS+1];
    logic signed [VALUE_BITS-1:0] tap_key    [MAX_ITEMS+1];
    logic        [IDX_W-1:0]      tap_target [MAX_ITEMS+1];
    logic        [IDX_W-1:0]      tap_count  [MAX_ITEMS+1];

    // Advance everything unless a finished result is still waiting.
    assign adv      = !m_tvalid || m_tready;
    assign s_tready = adv;
    assign accept   = s_tvalid && s_tready;
    assign full     = (seen_count_reg == SEEN_MAX);

    // Resize the sample to the comparison width, keeping its sign.
    generate
        if (VALUE_BITS <= IN_DATA_W)
        begin : g_narrow
            assign head_key = s_tdata[VALUE_BITS-1:0];
        end
        else
        begin : g_wide
            assign head_key = {{(VALUE_BITS-IN_DATA_W){s_tdata[IN_DATA_W-1]}}, s_tdata};
        end
    endgenerate

    // Build the admitted token: a full store marks it inactive and flags overflow.
    always_comb
    begin
        tap_ctrl[0].valid  = accept;
        tap_ctrl[0].active = !full;
        tap_ctrl[0].ovf    = full;
        tap_ctrl[0].last   = s_tlast;
        tap_key[0]         = head_key;
        tap_target[0]      = seen_count_reg[IDX_W-1:0];
        tap_count[0]       = '0;
    end

    // Hold on a full store, advance on room, drop back to zero after the last item.
    always_comb
    begin
        seen_count_next = seen_count_reg;
        if (accept)
        begin
            if (s_tlast)
            begin
                seen_count_next = '0;
            end
            else if (!full)
            begin
                seen_count_next = seen_count_reg + SEEN_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_count_reg <= '0;
        end
        else
        begin
            seen_count_reg <= seen_count_next;
        end
    end

    // Cell k stores the item whose target is k and compares every later item that found room
    // against that value as the item walks past.
    generate
        for (genvar k = 0; k < MAX_ITEMS; k++)
        begin : g_cell
            ipc_cell #(
                .INDEX      (k),
                .VALUE_BITS (VALUE_BITS),
                .IDX_W      (IDX_W)
            ) u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .adv        (adv),
                .in_ctrl    (tap_ctrl[k]),
                .in_key     (tap_key[k]),
                .in_target  (tap_target[k]),
                .in_count   (tap_count[k]),
                .out_ctrl   (tap_ctrl[k+1]),
                .out_key    (tap_key[k+1]),
                .out_target (tap_target[k+1]),
                .out_count  (tap_count[k+1])
            );
        end
    endgenerate

    // Fold each arriving count into the total; emit on the last item.
    ipc_tail #(
        .IDX_W    (IDX_W)
    ) u_tail (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (adv),
        .in_ctrl  (tap_ctrl[MAX_ITEMS]),
        .in_count (tap_count[MAX_ITEMS]),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .m_tdata  (m_tdata)
    );

    `IPC_ASSERT_NOW(a_seen_bound, 1'b1, seen_count_reg <= SEEN_MAX, "item count beyond capacity")
    `IPC_ASSERT_NEXT(a_last_clears, accept && s_tlast, seen_count_reg == '0, "count not cleared")
    `IPC_ASSERT_NEXT(a_count_step, accept && !s_tlast && !full, seen_count_reg == $past(seen_count_reg) + SEEN_W'(1), "count did not advance")
    `IPC_ASSERT_NOW(a_stall_blocks, m_tvalid && !m_tready, !s_tready, "input taken while result stalled")

endmodule
